/* sv/slf_pkg.sv */
`timescale 1ns / 1ps

package slf_pkg;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_FINISH = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_OPEN = 2'd1,
        ST_OVER    = 2'd2,
        ST_UNDER   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_SOF_FIRST  = 2'd0,
        REG_SOF_SECOND = 2'd1,
        REG_SOF_LEN    = 2'd2,
        REG_STUFF      = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_START,
        BK_WRITE,
        BK_FINISH
    } back_state_t;

    localparam int CFG_WIDTH = 8;
    localparam logic [1:0] SOF_LEN_RESET = 2'd2;

    // Start sequence steps
    localparam logic [2:0] STEP_SOF1   = 3'd0;
    localparam logic [2:0] STEP_SOF2   = 3'd1;
    localparam logic [2:0] STEP_LEN_HI = 3'd2;
    localparam logic [2:0] STEP_LEN_LO = 3'd3;

    typedef struct packed {
        logic [7:0] sof_first_byte;
        logic [7:0] sof_second_byte;
        logic [1:0] sof_seq_length;
        logic [7:0] stuff_byte;
    } cfg_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [15:0] frame_length;
        logic [31:0] value;
        logic [2:0]  size_bytes;   // normalized to 1..4
    } job_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_link_byte;
        logic [1:0] status;
        logic       last;
    } result_t;

endpackage

/* sv/slf_front.sv */
`timescale 1ns / 1ps

module slf_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          cmd,
    input  logic [15:0]         frame_length,
    input  logic [31:0]         value,
    input  logic [2:0]          size_bytes,
    output logic                job_valid,
    output slf_pkg::job_t       job,
    input  logic                job_pop
);

    slf_pkg::job_t q_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    logic          enq;
    logic [2:0]    size_norm;
    slf_pkg::job_t job_in;

    assign full      = (count_reg == 2'd2);
    assign job_valid = (count_reg != 2'd0);
    assign job       = q_reg[rd_ptr_reg];

    // Clamp size: zero acts as one, five to seven act as four
    always_comb
    begin
        case (size_bytes)
            3'd0:    size_norm = 3'd1;
            3'd1:    size_norm = 3'd1;
            3'd2:    size_norm = 3'd2;
            3'd3:    size_norm = 3'd3;
            default: size_norm = 3'd4;
        endcase
    end

    // Drop the unused command here; it yields no results
    assign enq = push && !full && (cmd != slf_pkg::CMD_NONE);

    always_comb
    begin
        job_in.cmd          = slf_pkg::cmd_t'(cmd);
        job_in.frame_length = frame_length;
        job_in.value        = value;
        job_in.size_bytes   = size_norm;
    end

    always_comb
    begin
        wr_ptr_next = enq ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = job_pop ? ~rd_ptr_reg : rd_ptr_reg;
        case ({enq, job_pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_reg[wr_ptr_reg] <= job_in;
        end
    end

endmodule

/* sv/slf_back.sv */
`timescale 1ns / 1ps

module slf_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  slf_pkg::cfg_t        cfg,
    input  logic                 job_valid,
    input  slf_pkg::job_t        job,
    output logic                 job_pop,
    input  logic                 res_room,
    output logic                 res_valid,
    output slf_pkg::result_t     res
);

    slf_pkg::back_state_t state_reg, state_next;
    slf_pkg::job_t        job_reg, job_next;
    logic [2:0]           idx_reg, idx_next;
    logic                 stuff_reg, stuff_next;
    logic                 open_reg, open_next;
    logic [15:0]          decl_reg, decl_next;
    logic [15:0]          bw_reg, bw_next;
    logic                 fire;
    logic                 done;
    logic                 load;
    logic [7:0]           cur_byte;

    always_comb
    begin
        case (idx_reg)
            3'd4:    cur_byte = job_reg.value[31:24];
            3'd3:    cur_byte = job_reg.value[23:16];
            3'd2:    cur_byte = job_reg.value[15:8];
            default: cur_byte = job_reg.value[7:0];
        endcase
    end

    assign fire      = (state_reg != slf_pkg::BK_IDLE) && res_room;
    assign res_valid = fire;

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        idx_next   = idx_reg;
        stuff_next = stuff_reg;
        open_next  = open_reg;
        decl_next  = decl_reg;
        bw_next    = bw_reg;
        done       = 1'b0;
        res        = '0;

        case (state_reg)
            slf_pkg::BK_START:
            begin
                res.is_link_byte = 1'b1;
                res.status       = slf_pkg::ST_OK;
                case (idx_reg)
                    slf_pkg::STEP_SOF1:   res.out_byte = cfg.sof_first_byte;
                    slf_pkg::STEP_SOF2:   res.out_byte = cfg.sof_second_byte;
                    slf_pkg::STEP_LEN_HI: res.out_byte = job_reg.frame_length[15:8];
                    default:              res.out_byte = job_reg.frame_length[7:0];
                endcase
                done = (idx_reg == slf_pkg::STEP_LEN_LO);
                if (fire)
                begin
                    // Skip the second start byte when the sequence length is below two
                    if ((idx_reg == slf_pkg::STEP_SOF1) && !cfg.sof_seq_length[1])
                        idx_next = slf_pkg::STEP_LEN_HI;
                    else
                        idx_next = idx_reg + 3'd1;
                    if (done)
                    begin
                        open_next = 1'b1;
                        decl_next = job_reg.frame_length;
                        bw_next   = 16'd0;
                    end
                end
            end

            slf_pkg::BK_WRITE:
            begin
                if (stuff_reg)
                begin
                    res.out_byte     = cfg.stuff_byte;
                    res.is_link_byte = 1'b1;
                    res.status       = slf_pkg::ST_OK;
                    done             = (idx_reg == 3'd0);
                    if (fire)
                        stuff_next = 1'b0;
                end
                else
                begin
                    if (!open_reg)
                        res.status = slf_pkg::ST_NO_OPEN;
                    else if (bw_reg >= decl_reg)
                        res.status = slf_pkg::ST_OVER;
                    else
                    begin
                        res.out_byte     = cur_byte;
                        res.is_link_byte = 1'b1;
                        res.status       = slf_pkg::ST_OK;
                    end
                    done = (idx_reg == 3'd1) &&
                           !(res.is_link_byte && (cur_byte == cfg.sof_first_byte));
                    if (fire)
                    begin
                        idx_next = idx_reg - 3'd1;
                        if (res.is_link_byte)
                        begin
                            bw_next    = bw_reg + 16'd1;
                            stuff_next = (cur_byte == cfg.sof_first_byte);
                        end
                    end
                end
            end

            slf_pkg::BK_FINISH:
            begin
                if (!open_reg)
                    res.status = slf_pkg::ST_NO_OPEN;
                else if (bw_reg != decl_reg)
                    res.status = slf_pkg::ST_UNDER;
                else
                    res.status = slf_pkg::ST_OK;
                done = 1'b1;
            end

            default:
            begin
                done = 1'b0;
            end
        endcase

        res.last = done;

        // Take the next job as soon as the current one retires
        load    = (state_reg == slf_pkg::BK_IDLE) || (fire && done);
        job_pop = load && job_valid;
        if (load)
        begin
            stuff_next = 1'b0;
            if (job_valid)
            begin
                job_next = job;
                case (job.cmd)
                    slf_pkg::CMD_START:
                    begin
                        state_next = slf_pkg::BK_START;
                        idx_next   = slf_pkg::STEP_SOF1;
                    end
                    slf_pkg::CMD_WRITE:
                    begin
                        state_next = slf_pkg::BK_WRITE;
                        idx_next   = job.size_bytes;
                    end
                    slf_pkg::CMD_FINISH:
                    begin
                        state_next = slf_pkg::BK_FINISH;
                    end
                    default:
                    begin
                        state_next = slf_pkg::BK_IDLE;
                    end
                endcase
            end
            else
            begin
                state_next = slf_pkg::BK_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= slf_pkg::BK_IDLE;
            idx_reg   <= 3'd0;
            stuff_reg <= 1'b0;
            open_reg  <= 1'b0;
            decl_reg  <= 16'd0;
            bw_reg    <= 16'd0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            stuff_reg <= stuff_next;
            open_reg  <= open_next;
            decl_reg  <= decl_next;
            bw_reg    <= bw_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

endmodule

/* sv/slf_outq.sv */
`timescale 1ns / 1ps

module slf_outq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr,
    input  slf_pkg::result_t    wr_data,
    output logic                room,
    output logic                empty,
    input  logic                pop,
    output slf_pkg::result_t    head
);

    slf_pkg::result_t q_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             deq;

    assign room  = (count_reg != 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = q_reg[rd_ptr_reg];
    assign deq   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = deq ? ~rd_ptr_reg : rd_ptr_reg;
        case ({wr, deq})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            q_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* sv/sof_length_framer_with_stuffing.sv */
`timescale 1ns / 1ps

// Channel   Ports                                         Taken when
// request   push, full, cmd, frame_length, value,         push && !full
//           size_bytes
// result    empty, pop, out_byte, is_link_byte,           pop && !empty
//           status, last
// config    cfg_we, cfg_index, cfg_data                   cfg_we
//
// The back sequencer emits one result per cycle unless stalled: a start
// request yields 3 or 4 results, a write request 1 to 8 (one per byte plus
// one per stuff byte), a finish request 1. Requests queue two deep ahead of
// the sequencer, results two deep behind it, so consecutive requests run
// with no gap between them. Reset clears the queues, the packet state and
// the config registers (start sequence length resets to two). A full result
// queue stalls the sequencer; a full request queue raises full.

module sof_length_framer_with_stuffing (
    input  logic        clk,
    input  logic        rst_n,
    // request side
    input  logic        push,
    output logic        full,
    input  logic [1:0]  cmd,
    input  logic [15:0] frame_length,
    input  logic [31:0] value,
    input  logic [2:0]  size_bytes,
    // result side
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        is_link_byte,
    output logic [1:0]  status,
    output logic        last,
    // config write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [slf_pkg::CFG_WIDTH-1:0] cfg_data
);

    slf_pkg::cfg_t    cfg_reg, cfg_next;
    logic             job_valid;
    slf_pkg::job_t    job;
    logic             job_pop;
    logic             res_valid;
    logic             res_room;
    slf_pkg::result_t res;
    slf_pkg::result_t head;

    // Config registers: write by index, hold otherwise
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                slf_pkg::REG_SOF_FIRST:  cfg_next.sof_first_byte  = cfg_data;
                slf_pkg::REG_SOF_SECOND: cfg_next.sof_second_byte = cfg_data;
                slf_pkg::REG_SOF_LEN:    cfg_next.sof_seq_length  = cfg_data[1:0];
                slf_pkg::REG_STUFF:      cfg_next.stuff_byte      = cfg_data;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sof_first_byte  <= 8'd0;
            cfg_reg.sof_second_byte <= 8'd0;
            cfg_reg.sof_seq_length  <= slf_pkg::SOF_LEN_RESET;
            cfg_reg.stuff_byte      <= 8'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: accept requests, normalize size, drop the unused command
    slf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .cmd          (cmd),
        .frame_length (frame_length),
        .value        (value),
        .size_bytes   (size_bytes),
        .job_valid    (job_valid),
        .job          (job),
        .job_pop      (job_pop)
    );

    // Back: walk each request byte by byte, track the open packet
    slf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop),
        .res_room  (res_room),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result queue decouples the sequencer from the consumer
    slf_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (res_valid),
        .wr_data (res),
        .room    (res_room),
        .empty   (empty),
        .pop     (pop),
        .head    (head)
    );

    assign out_byte     = head.out_byte;
    assign is_link_byte = head.is_link_byte;
    assign status       = head.status;
    assign last         = head.last;

    // Sequencer never writes a full result queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_room)
        else $error("result written into full queue");

    // Sequencer only takes a job that is queued
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> job_valid)
        else $error("job taken from empty queue");

    // Link bytes always carry ok status; status reports carry a zero byte
    a_link_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && is_link_byte) |-> (status == slf_pkg::ST_OK))
        else $error("link byte with error status");

    a_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !is_link_byte) |-> (out_byte == 8'd0))
        else $error("status report with nonzero byte");

endmodule
